@@ sv/dbd_pkg.sv @@
// dbd_pkg: shared types, constants and codes for the dribbler ball detector
// depends on nothing; used by dbd_speed_ring and dribbler_ball_detector
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

  // ring depths and the delayed tap (depths are powers of two)
  localparam int AVG_DEPTH = 16;
  localparam int CMD_DEPTH = 8;
  localparam int DELAY_TAP = 4;
  localparam int PWM_FULL  = 10000;

  localparam int AVG_LOG2 = $clog2(AVG_DEPTH);
  localparam int CMD_LOG2 = $clog2(CMD_DEPTH);

  // shift-line index of the delayed entry: newest entry sits at index 0
  localparam int DELAY_IDX = ((DELAY_TAP % AVG_DEPTH) + AVG_DEPTH - 1) % AVG_DEPTH;

  // field widths
  localparam int SPEED_W   = 24;
  localparam int SCALE_W   = 16;
  localparam int CMD_W     = 15;
  localparam int DUTY_W    = 14;
  localparam int PWM_W     = 16;
  localparam int SPD_SUM_W = SPEED_W + AVG_LOG2;
  localparam int CMD_SUM_W = CMD_W + CMD_LOG2;
  localparam int CFG_W     = 24;

  // Q2.14 full scale and duty ceiling
  localparam logic [CMD_W-1:0]  CMD_FULL = CMD_W'(16384);
  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};
  localparam logic [PWM_W-1:0]  PWM_FULL_V = PWM_W'(PWM_FULL);

  // register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(256);
  localparam logic [SPEED_W-1:0] MIN_RST    = SPEED_W'(2560);
  localparam logic [SPEED_W-1:0] MARGIN_RST = SPEED_W'(1280);
  localparam logic [CMD_W-1:0]   OFF_RST    = CMD_W'(819);

  // item kinds
  typedef enum logic {
    CMD_SET_SPEED  = 1'b0,
    CMD_ENC_SAMPLE = 1'b1
  } cmd_kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPEED_SCALE = 2'd0,
    CFG_MIN_SPEED   = 2'd1,
    CFG_MARGIN      = 2'd2,
    CFG_OFF_LEVEL   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    cmd_kind_t          command;
    logic signed [15:0] command_speed;
    logic signed [15:0] encoder_count;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  pwm_duty;
    logic [SPEED_W-1:0] measured_speed;
    logic [SPEED_W-1:0] filtered_speed;
    logic [SPEED_W-1:0] speed_before_ball;
    logic               has_ball;
  } out_t;

  // what the speed ring reports for a pushed sample
  typedef struct packed {
    logic [SPEED_W-1:0] avg;
    logic [SPEED_W-1:0] delayed;
  } ring_stat_t;

endpackage

`default_nettype wire

@@ sv/dribbler_ball_detector.sv @@
// a request is captured in the input register when accepted and its result is
//   written to the result register (out_data) once the input stage advances
// throughput: one request per cycle while the result is not blocked; input register
//   and result register form a two-stage pipeline, and the update is single-pass
// reset (rst_n, synchronous, active low): rings, sums, detector state and
//   handshake valids cleared, registers back to their defaults
// depends on dbd_pkg and dbd_speed_ring
`timescale 1ns / 1ps
`default_nettype none

module dribbler_ball_detector (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire dbd_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output dbd_pkg::out_t                  out_data,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [dbd_pkg::CFG_W-1:0] cfg_wdata
);

  // configuration registers
  logic [dbd_pkg::SCALE_W-1:0] scale_r;
  logic [dbd_pkg::SPEED_W-1:0] min_r;
  logic [dbd_pkg::SPEED_W-1:0] margin_r;
  logic [dbd_pkg::CMD_W-1:0]   off_r;

  // pipeline registers
  dbd_pkg::in_t  in_r;
  logic          in_vld_r;
  dbd_pkg::out_t out_r;
  logic          out_vld_r;
  logic          advance;

  // detector state
  logic [dbd_pkg::CMD_W-1:0]     cmd_hist_r [dbd_pkg::CMD_DEPTH];
  logic [dbd_pkg::CMD_SUM_W-1:0] cmd_sum_r, cmd_sum_nxt;
  logic [dbd_pkg::SPEED_W-1:0]   speed_r, speed_nxt;
  logic [dbd_pkg::SPEED_W-1:0]   avg_r, avg_nxt;
  logic [dbd_pkg::SPEED_W-1:0]   rec_r, rec_nxt;
  logic                          ball_r, ball_nxt;
  logic [dbd_pkg::DUTY_W-1:0]    duty_r, duty_nxt;

  // datapath intermediates
  logic                          is_enc;
  logic [dbd_pkg::CMD_W-1:0]     cmd_clamp;
  logic [dbd_pkg::CMD_W+dbd_pkg::PWM_W-1:0] duty_prod;
  logic [dbd_pkg::CMD_W+dbd_pkg::PWM_W-15:0] duty_full;
  logic [16:0]                   enc_mag;
  logic [32:0]                   speed_prod;
  logic [dbd_pkg::SPEED_W-1:0]   speed_new;
  dbd_pkg::ring_stat_t           ring_stat;
  logic [dbd_pkg::SPEED_W:0]     now_marg;
  logic                          reducing, increasing, take, ball_mid, recovered, cmd_off;
  logic [dbd_pkg::SPEED_W-1:0]   rec_new;
  logic                          ball_new;

  // handshake: input stage moves on when the result register can take it
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign is_enc    = (in_r.command == dbd_pkg::CMD_ENC_SAMPLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= dbd_pkg::SCALE_RST;
      min_r    <= dbd_pkg::MIN_RST;
      margin_r <= dbd_pkg::MARGIN_RST;
      off_r    <= dbd_pkg::OFF_RST;
    end else if (cfg_we) begin
      case (dbd_pkg::cfg_idx_t'(cfg_index))
        dbd_pkg::CFG_SPEED_SCALE: scale_r  <= cfg_wdata[dbd_pkg::SCALE_W-1:0];
        dbd_pkg::CFG_MIN_SPEED:   min_r    <= cfg_wdata[dbd_pkg::SPEED_W-1:0];
        dbd_pkg::CFG_MARGIN:      margin_r <= cfg_wdata[dbd_pkg::SPEED_W-1:0];
        dbd_pkg::CFG_OFF_LEVEL:   off_r    <= cfg_wdata[dbd_pkg::CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // command path: clamp, running sum, duty
  always_comb begin
    if (in_r.command_speed[15]) begin
      cmd_clamp = '0;
    end else if (in_r.command_speed[14:0] > dbd_pkg::CMD_FULL) begin
      cmd_clamp = dbd_pkg::CMD_FULL;
    end else begin
      cmd_clamp = in_r.command_speed[14:0];
    end
    cmd_sum_nxt = cmd_sum_r
                - {{dbd_pkg::CMD_LOG2{1'b0}}, cmd_hist_r[dbd_pkg::CMD_DEPTH-1]}
                + {{dbd_pkg::CMD_LOG2{1'b0}}, cmd_clamp};
    duty_prod = {{dbd_pkg::PWM_W{1'b0}}, cmd_clamp} * {{dbd_pkg::CMD_W{1'b0}},
                dbd_pkg::PWM_FULL_V};
    duty_full = duty_prod[dbd_pkg::CMD_W+dbd_pkg::PWM_W-1:14];
    if (duty_full > {{(dbd_pkg::CMD_W+dbd_pkg::PWM_W-14-dbd_pkg::DUTY_W){1'b0}},
                     dbd_pkg::DUTY_MAX}) begin
      duty_nxt = dbd_pkg::DUTY_MAX;
    end else begin
      duty_nxt = duty_full[dbd_pkg::DUTY_W-1:0];
    end
  end

  // encoder path: absolute count times scale
  always_comb begin
    if (in_r.encoder_count[15]) begin
      enc_mag = 17'd0 - {in_r.encoder_count[15], in_r.encoder_count};
    end else begin
      enc_mag = {1'b0, in_r.encoder_count};
    end
    speed_prod = {16'd0, enc_mag} * {17'd0, scale_r};
    speed_new  = speed_prod[8 +: dbd_pkg::SPEED_W];
  end

  dbd_speed_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (advance && is_enc),
    .speed_in (speed_new),
    .stat     (ring_stat)
  );

  // hysteretic ball detection on the new average
  always_comb begin
    now_marg   = {1'b0, ring_stat.avg} + {1'b0, margin_r};
    reducing   = now_marg < {1'b0, avg_r};
    increasing = ring_stat.avg > avg_r;
    if (!ball_r && ring_stat.delayed > min_r) begin
      rec_new = ring_stat.delayed;
    end else begin
      rec_new = rec_r;
    end
    take      = reducing && (ring_stat.avg > min_r) && (cmd_sum_r != '0);
    ball_mid  = ball_r || take;
    recovered = increasing && (now_marg > {1'b0, rec_new});
    cmd_off   = cmd_sum_r < {off_r, {dbd_pkg::CMD_LOG2{1'b0}}};
    ball_new  = ball_mid && !(recovered || cmd_off);
  end

  // next state by item kind
  always_comb begin
    if (is_enc) begin
      speed_nxt = speed_new;
      avg_nxt   = ring_stat.avg;
      rec_nxt   = rec_new;
      ball_nxt  = ball_new;
    end else begin
      speed_nxt = speed_r;
      avg_nxt   = avg_r;
      rec_nxt   = rec_r;
      ball_nxt  = ball_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_sum_r <= '0;
      speed_r   <= '0;
      avg_r     <= '0;
      rec_r     <= '0;
      ball_r    <= 1'b0;
      duty_r    <= '0;
      for (int i = 0; i < dbd_pkg::CMD_DEPTH; i++) cmd_hist_r[i] <= '0;
    end else if (advance) begin
      speed_r <= speed_nxt;
      avg_r   <= avg_nxt;
      rec_r   <= rec_nxt;
      ball_r  <= ball_nxt;
      if (!is_enc) begin
        cmd_sum_r     <= cmd_sum_nxt;
        duty_r        <= duty_nxt;
        cmd_hist_r[0] <= cmd_clamp;
        for (int i = 1; i < dbd_pkg::CMD_DEPTH; i++) cmd_hist_r[i] <= cmd_hist_r[i-1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.pwm_duty          <= is_enc ? duty_r : duty_nxt;
      out_r.measured_speed    <= speed_nxt;
      out_r.filtered_speed    <= avg_nxt;
      out_r.speed_before_ball <= rec_nxt;
      out_r.has_ball          <= ball_nxt;
    end
  end

  // a command request never moves the detector
  a_cmd_keeps_ball: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !is_enc |=> ball_r == $past(ball_r) && rec_r == $past(rec_r))
    else $error("command request changed detector state");

  // recovery level is frozen while a ball is held
  a_rec_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ball_r |=> rec_r == $past(rec_r))
    else $error("recovery level moved with ball held");

  // input stage only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && out_vld_r && !out_ready)
    else $error("input stalled without a blocked result");

  // command sum never exceeds a full ring of full-scale commands
  a_cmd_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_sum_r <= dbd_pkg::CMD_SUM_W'(dbd_pkg::CMD_DEPTH * 16384))
    else $error("command sum out of range");

  // duty stays within full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.pwm_duty <= dbd_pkg::DUTY_W'(dbd_pkg::PWM_FULL))
    else $error("duty above full scale");

endmodule

`default_nettype wire

@@ sv/dbd_speed_ring.sv @@
// dbd_speed_ring: moving-average speed history as a shift line with running sum
// depends on dbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbd_speed_ring (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [dbd_pkg::SPEED_W-1:0] speed_in,
  output dbd_pkg::ring_stat_t              stat
);

  logic [dbd_pkg::SPEED_W-1:0]   hist_r [dbd_pkg::AVG_DEPTH];
  logic [dbd_pkg::SPD_SUM_W-1:0] sum_r;
  logic [dbd_pkg::SPD_SUM_W-1:0] sum_nxt;

  // running sum: oldest entry leaves, new sample enters
  always_comb begin
    sum_nxt = sum_r
            - {{dbd_pkg::AVG_LOG2{1'b0}}, hist_r[dbd_pkg::AVG_DEPTH-1]}
            + {{dbd_pkg::AVG_LOG2{1'b0}}, speed_in};
  end

  assign stat.avg = sum_nxt[dbd_pkg::SPD_SUM_W-1:dbd_pkg::AVG_LOG2];

  // delayed entry as seen after the push
  generate
    if (dbd_pkg::DELAY_IDX == 0) begin : g_tap_new
      assign stat.delayed = speed_in;
    end else begin : g_tap_old
      assign stat.delayed = hist_r[dbd_pkg::DELAY_IDX-1];
    end
  endgenerate

  // shift line and sum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < dbd_pkg::AVG_DEPTH; i++) hist_r[i] <= '0;
    end else if (push) begin
      sum_r     <= sum_nxt;
      hist_r[0] <= speed_in;
      for (int i = 1; i < dbd_pkg::AVG_DEPTH; i++) hist_r[i] <= hist_r[i-1];
    end
  end

endmodule

`default_nettype wire
